// ===== hdl/limit_order_matching_engine_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LIMIT_ORDER_MATCHING_ENGINE_TOP_MACROS_SVH
`define LIMIT_ORDER_MATCHING_ENGINE_TOP_MACROS_SVH
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LOM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lom check failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LOM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lom check failed");
`endif

// ===== hdl/lom_pkg.sv =====
// Shared types and constants of the order matching engine.
`timescale 1ns / 1ps
package lom_pkg;
    localparam int SLOTS      = 32;
    localparam int MAX_TRADES = 63;
    localparam int CNT_W      = 6;

    localparam logic       SIDE_BUY     = 1'b0;
    localparam logic       KIND_MARKET  = 1'b1;
    localparam logic       REC_TRADE    = 1'b0;
    localparam logic       REC_STATUS   = 1'b1;
    localparam logic [1:0] OUT_FILLED   = 2'd0;
    localparam logic [1:0] OUT_RESTED   = 2'd1;
    localparam logic [1:0] OUT_DROPPED  = 2'd2;
    localparam logic [1:0] OUT_REJECTED = 2'd3;

    typedef struct packed {
        logic        side;
        logic        order_kind;
        logic [7:0]  price_tick;
        logic [15:0] quantity;
        logic [31:0] order_id;
        logic [47:0] timestamp;
    } t_order;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] trade_id;
        logic [31:0] buy_order_id;
        logic [31:0] sell_order_id;
        logic [7:0]  trade_price;
        logic [15:0] fill_quantity;
        logic [47:0] trade_time;
        logic [1:0]  outcome;
        logic        last;
    } t_record;

    typedef struct packed {
        logic        valid;
        logic [7:0]  price;
        logic [31:0] id;
        logic [15:0] qty;
    } t_entry;

    typedef struct packed {
        logic        pop;
        logic        upd;
        logic [15:0] upd_qty;
        logic        ins;
        t_entry      ins_entry;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FINISH
    } t_state;
endpackage

// ===== hdl/lom_cell.sv =====
// One resting-order cell of a sorted book chain.
`timescale 1ns / 1ps
module lom_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lom_pkg::t_chain_ctl i_ctl,
    input  logic                i_is_bid,
    input  logic                i_first,
    input  lom_pkg::t_entry     i_prev,
    input  logic                i_prev_before,
    input  lom_pkg::t_entry     i_next,
    output lom_pkg::t_entry     o_entry,
    output logic                o_before
);
    lom_pkg::t_entry r_entry;
    lom_pkg::t_entry n_entry;

    // New order goes ahead of this one on a strictly better price, or if this cell is empty.
    assign o_before = !r_entry.valid ||
        (i_is_bid ? (i_ctl.ins_entry.price > r_entry.price)
                  : (i_ctl.ins_entry.price < r_entry.price));

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.pop) begin
            n_entry = i_next;
        end else if (i_ctl.upd && i_first) begin
            n_entry.qty = i_ctl.upd_qty;
        end else if (i_ctl.ins && o_before) begin
            n_entry = i_prev_before ? i_prev : i_ctl.ins_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
endmodule

// ===== hdl/lom_chain.sv =====
// Row of cells holding one side of the book in priority order.
`timescale 1ns / 1ps
module lom_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_is_bid,
    input  lom_pkg::t_chain_ctl i_ctl,
    output lom_pkg::t_entry     o_head,
    output logic                o_full
);
    lom_pkg::t_entry w_entry  [lom_pkg::SLOTS];
    logic            w_before [lom_pkg::SLOTS];

    for (genvar g = 0; g < lom_pkg::SLOTS; g++) begin : g_cell
        lom_pkg::t_entry w_prev;
        lom_pkg::t_entry w_next;
        logic            w_prev_before;
        if (g == 0) begin : g_lo
            assign w_prev        = '0;
            assign w_prev_before = 1'b0;
        end else begin : g_mid
            assign w_prev        = w_entry[g-1];
            assign w_prev_before = w_before[g-1];
        end
        if (g == lom_pkg::SLOTS - 1) begin : g_hi
            assign w_next = '0;
        end else begin : g_nx
            assign w_next = w_entry[g+1];
        end
        lom_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_is_bid      (i_is_bid),
            .i_first       (g == 0),
            .i_prev        (w_prev),
            .i_prev_before (w_prev_before),
            .i_next        (w_next),
            .o_entry       (w_entry[g]),
            .o_before      (w_before[g])
        );
    end

    assign o_head = w_entry[0];
    assign o_full = w_entry[lom_pkg::SLOTS-1].valid;
endmodule

// ===== hdl/limit_order_matching_engine_top.sv =====
// Top level: order matching engine over two sorted cell chains.
// The status record is strobed after the T trades of an order (at most 63 trades);
//   trades are strobed one per cycle, the first once the order is registered in ST_MATCH.
// A new order is taken only while busy is low; busy is high from acceptance on
//   and drops in the cycle that strobes the status record, so the next order is taken then.
// Each side's head cell is the best resting order, so a trade reads only the opposite head.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Synchronous active-low reset empties both books and sets the trade counter to 1.
`timescale 1ns / 1ps
module limit_order_matching_engine_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  lom_pkg::t_order  i_order,
    output logic             busy,
    output logic             o_strobe,
    output lom_pkg::t_record o_record
);
    lom_pkg::t_state  r_state, n_state;
    lom_pkg::t_order  r_ord, n_ord;
    logic [15:0]      r_qty, n_qty;
    logic [lom_pkg::CNT_W-1:0] r_ntr, n_ntr;
    logic [31:0]      r_tc, n_tc;
    logic             r_valid, n_valid;
    lom_pkg::t_record r_rec, n_rec;

    lom_pkg::t_chain_ctl w_bid_ctl, w_ask_ctl, w_opp_ctl, w_own_ctl;
    lom_pkg::t_entry     w_bid_head, w_ask_head, w_head;
    logic                w_bid_full, w_ask_full, w_own_full;
    logic                w_cross, w_trade;
    logic [15:0]         w_fill;

    lom_chain u_bids (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_is_bid (1'b1),
        .i_ctl (w_bid_ctl), .o_head (w_bid_head), .o_full (w_bid_full)
    );
    lom_chain u_asks (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_is_bid (1'b0),
        .i_ctl (w_ask_ctl), .o_head (w_ask_head), .o_full (w_ask_full)
    );

    // Buyers sweep the asks, sellers the bids; each rests on its own side.
    assign w_head     = (r_ord.side == lom_pkg::SIDE_BUY) ? w_ask_head : w_bid_head;
    assign w_own_full = (r_ord.side == lom_pkg::SIDE_BUY) ? w_bid_full : w_ask_full;
    assign w_bid_ctl  = (r_ord.side == lom_pkg::SIDE_BUY) ? w_own_ctl : w_opp_ctl;
    assign w_ask_ctl  = (r_ord.side == lom_pkg::SIDE_BUY) ? w_opp_ctl : w_own_ctl;

    // Price crosses when the best opposite level exists and is within the limit; a market order crosses any level.
    assign w_cross = w_head.valid &&
        ((r_ord.order_kind == lom_pkg::KIND_MARKET) ||
         ((r_ord.side == lom_pkg::SIDE_BUY) ? (r_ord.price_tick >= w_head.price)
                                            : (r_ord.price_tick <= w_head.price)));
    assign w_trade = (r_qty != 16'd0) && (r_ntr != lom_pkg::CNT_W'(lom_pkg::MAX_TRADES))
                     && w_cross;
    assign w_fill  = (r_qty < w_head.qty) ? r_qty : w_head.qty;

    always_comb begin
        n_state   = r_state;
        n_ord     = r_ord;
        n_qty     = r_qty;
        n_ntr     = r_ntr;
        n_tc      = r_tc;
        n_valid   = 1'b0;
        n_rec     = r_rec;
        w_opp_ctl = '0;
        w_own_ctl = '0;
        unique case (r_state)
            lom_pkg::ST_IDLE: begin
                if (start) begin
                    // Take the transaction and start sweeping.
                    n_ord   = i_order;
                    n_qty   = i_order.quantity;
                    n_ntr   = '0;
                    n_state = lom_pkg::ST_MATCH;
                end
            end
            lom_pkg::ST_MATCH: begin
                if (w_trade) begin
                    // Emit one trade at the resting price; pop a filled head.
                    n_valid             = 1'b1;
                    n_rec               = '0;
                    n_rec.record_kind   = lom_pkg::REC_TRADE;
                    n_rec.trade_id      = r_tc;
                    n_rec.buy_order_id  = (r_ord.side == lom_pkg::SIDE_BUY) ? r_ord.order_id
                                                                             : w_head.id;
                    n_rec.sell_order_id = (r_ord.side == lom_pkg::SIDE_BUY) ? w_head.id
                                                                             : r_ord.order_id;
                    n_rec.trade_price   = w_head.price;
                    n_rec.fill_quantity = w_fill;
                    n_rec.trade_time    = r_ord.timestamp;
                    n_rec.outcome       = lom_pkg::OUT_FILLED;
                    n_tc                = r_tc + 32'd1;
                    n_ntr               = r_ntr + 1'b1;
                    n_qty               = r_qty - w_fill;
                    if (w_fill == w_head.qty) begin
                        w_opp_ctl.pop = 1'b1;
                    end else begin
                        w_opp_ctl.upd     = 1'b1;
                        w_opp_ctl.upd_qty = w_head.qty - w_fill;
                    end
                end else begin
                    n_state = lom_pkg::ST_FINISH;
                end
            end
            lom_pkg::ST_FINISH: begin
                // Settle the remainder and emit the status record.
                n_valid             = 1'b1;
                n_rec               = '0;
                n_rec.record_kind   = lom_pkg::REC_STATUS;
                n_rec.buy_order_id  = (r_ord.side == lom_pkg::SIDE_BUY) ? r_ord.order_id : '0;
                n_rec.sell_order_id = (r_ord.side == lom_pkg::SIDE_BUY) ? '0 : r_ord.order_id;
                n_rec.trade_price   = r_ord.price_tick;
                n_rec.fill_quantity = r_qty;
                n_rec.trade_time    = r_ord.timestamp;
                n_rec.last          = 1'b1;
                priority if (r_qty == 16'd0) begin
                    n_rec.outcome = lom_pkg::OUT_FILLED;
                end else if (r_ord.order_kind == lom_pkg::KIND_MARKET) begin
                    n_rec.outcome = lom_pkg::OUT_DROPPED;
                end else if (w_own_full) begin
                    n_rec.outcome = lom_pkg::OUT_REJECTED;
                end else begin
                    n_rec.outcome             = lom_pkg::OUT_RESTED;
                    w_own_ctl.ins             = 1'b1;
                    w_own_ctl.ins_entry.valid = 1'b1;
                    w_own_ctl.ins_entry.price = r_ord.price_tick;
                    w_own_ctl.ins_entry.id    = r_ord.order_id;
                    w_own_ctl.ins_entry.qty   = r_qty;
                end
                n_state = lom_pkg::ST_IDLE;
            end
            default: begin
                n_state = lom_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lom_pkg::ST_IDLE;
            r_tc    <= 32'd1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tc    <= n_tc;
            r_valid <= n_valid;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_ord <= n_ord;
        r_qty <= n_qty;
        r_ntr <= n_ntr;
        r_rec <= n_rec;
    end

    assign busy     = (r_state != lom_pkg::ST_IDLE);
    assign o_strobe = r_valid;
    assign o_record = r_rec;
endmodule

// ===== hdl/lom_checker.sv =====
// Port-level checks of the matching engine, bound to the top level.
`timescale 1ns / 1ps
`include "limit_order_matching_engine_top_macros.svh"
module lom_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_strobe,
    input lom_pkg::t_record o_record
);
    `LOM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `LOM_ASSERT_NOW(a_status_last, o_strobe && o_record.record_kind == lom_pkg::REC_STATUS, o_record.last)
    `LOM_ASSERT_NOW(a_trade_busy, o_strobe && o_record.record_kind == lom_pkg::REC_TRADE, busy && !o_record.last)
    `LOM_ASSERT_NOW(a_last_idle, o_strobe && o_record.last, !busy)
endmodule

bind limit_order_matching_engine_top lom_checker u_lom_checker (.*);

// ===== sim/tb_limit_order_matching_engine_top.sv =====
// Self-checking testbench of the order matching engine with a price-time book predictor.
`timescale 1ns / 1ps
module tb_limit_order_matching_engine_top;
    localparam int LEVELS    = 256;
    localparam int N_RANDOM  = 388;
    localparam int CYC_LIMIT = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    lom_pkg::t_order  i_order = '0;
    logic             busy;
    logic             o_strobe;
    lom_pkg::t_record o_record;

    limit_order_matching_engine_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_order(i_order),
        .busy(busy), .o_strobe(o_strobe), .o_record(o_record)
    );

    always #5 i_clk = ~i_clk;

    // Book state of the predictor: index 0 bids, index 1 asks.
    bit          lvl_occ  [2][LEVELS];
    logic [4:0]  lvl_head [2][LEVELS];
    logic [4:0]  lvl_tail [2][LEVELS];
    logic [31:0] slot_id  [2][lom_pkg::SLOTS];
    logic [15:0] slot_qty [2][lom_pkg::SLOTS];
    logic [4:0]  slot_next[2][lom_pkg::SLOTS];
    bit          slot_used[2][lom_pkg::SLOTS];
    logic [31:0] next_trade_id = 32'd1;

    lom_pkg::t_order  pending_orders[$];
    lom_pkg::t_record expected_records[$];

    int  idle_pct = 0;
    bit  drain_hold = 1'b0;
    bit  stim_done = 1'b0;
    int  n_errors = 0;
    int  n_records = 0;
    int  n_trades = 0;
    int  n_orders = 0;
    int  cycles = 0;
    int  outcome_seen[4];

    // Append an order to the stimulus queue.
    task automatic queue_order(input lom_pkg::t_order o);
        pending_orders = {pending_orders, o};
    endtask

    // Append a record to the expectation queue.
    task automatic expect_record(input lom_pkg::t_record r);
        expected_records = {expected_records, r};
    endtask

    // Best opposite level: highest bid for a sell, lowest ask for a buy; -1 if empty.
    function automatic int best_price(int bk);
        if (bk == 0) begin
            for (int p = LEVELS - 1; p >= 0; p--) if (lvl_occ[0][p]) return p;
        end else begin
            for (int p = 0; p < LEVELS; p++) if (lvl_occ[1][p]) return p;
        end
        return -1;
    endfunction

    // Match one order against the book; queue the trades and status it causes.
    task automatic match_order(input lom_pkg::t_order o);
        int               own;
        int               opp;
        int               lvl;
        int               n;
        int               fs;
        logic [4:0]       sl;
        logic [15:0]      qty;
        logic [15:0]      fill;
        logic [1:0]       res;
        lom_pkg::t_record r;
        own = o.side;
        opp = own ^ 1;
        qty = o.quantity;
        n   = 0;
        while (qty != 0 && n < lom_pkg::MAX_TRADES) begin
            lvl = best_price(opp);
            if (lvl < 0) break;
            if (o.order_kind != lom_pkg::KIND_MARKET) begin
                if (o.side == lom_pkg::SIDE_BUY && o.price_tick < lvl) break;
                if (o.side != lom_pkg::SIDE_BUY && o.price_tick > lvl) break;
            end
            sl   = lvl_head[opp][lvl];
            fill = (qty < slot_qty[opp][sl]) ? qty : slot_qty[opp][sl];
            r = '0;
            r.record_kind   = lom_pkg::REC_TRADE;
            r.trade_id      = next_trade_id;
            r.buy_order_id  = (o.side == lom_pkg::SIDE_BUY) ? o.order_id : slot_id[opp][sl];
            r.sell_order_id = (o.side == lom_pkg::SIDE_BUY) ? slot_id[opp][sl] : o.order_id;
            r.trade_price   = lvl[7:0];
            r.fill_quantity = fill;
            r.trade_time    = o.timestamp;
            r.outcome       = lom_pkg::OUT_FILLED;
            expect_record(r);
            n++;
            n_trades++;
            next_trade_id++;
            qty -= fill;
            slot_qty[opp][sl] -= fill;
            if (slot_qty[opp][sl] == 0) begin
                slot_used[opp][sl] = 1'b0;
                if (sl == lvl_tail[opp][lvl]) lvl_occ[opp][lvl] = 1'b0;
                else lvl_head[opp][lvl] = slot_next[opp][sl];
            end
        end
        if (qty == 0) res = lom_pkg::OUT_FILLED;
        else if (o.order_kind == lom_pkg::KIND_MARKET) res = lom_pkg::OUT_DROPPED;
        else begin
            fs = -1;
            for (int s = 0; s < lom_pkg::SLOTS; s++) if (!slot_used[own][s] && fs < 0) fs = s;
            if (fs < 0) res = lom_pkg::OUT_REJECTED;
            else begin
                slot_used[own][fs] = 1'b1;
                slot_id[own][fs]   = o.order_id;
                slot_qty[own][fs]  = qty;
                slot_next[own][fs] = '0;
                if (lvl_occ[own][o.price_tick]) begin
                    slot_next[own][lvl_tail[own][o.price_tick]] = fs[4:0];
                end else begin
                    lvl_occ[own][o.price_tick]  = 1'b1;
                    lvl_head[own][o.price_tick] = fs[4:0];
                end
                lvl_tail[own][o.price_tick] = fs[4:0];
                res = lom_pkg::OUT_RESTED;
            end
        end
        r = '0;
        r.record_kind   = lom_pkg::REC_STATUS;
        r.buy_order_id  = (o.side == lom_pkg::SIDE_BUY) ? o.order_id : '0;
        r.sell_order_id = (o.side == lom_pkg::SIDE_BUY) ? '0 : o.order_id;
        r.trade_price   = o.price_tick;
        r.fill_quantity = qty;
        r.trade_time    = o.timestamp;
        r.outcome       = res;
        r.last          = 1'b1;
        expect_record(r);
        outcome_seen[res]++;
    endtask

    function automatic lom_pkg::t_order make_order(bit sd, bit mk, int px, int qty);
        lom_pkg::t_order o;
        o.side       = sd;
        o.order_kind = mk;
        o.price_tick = px[7:0];
        o.quantity   = qty[15:0];
        o.order_id   = $urandom;
        o.timestamp  = {16'($urandom), $urandom};
        return o;
    endfunction

    // Driver: hold start until the engine takes the transaction, then advance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            match_order(i_order);
            n_orders++;
            if (pending_orders.size() > 0 && !drain_hold &&
                $urandom_range(99) >= idle_pct) begin
                i_order <= pending_orders[0];
                pending_orders.delete(0);
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_orders.size() > 0 && !drain_hold &&
                     $urandom_range(99) >= idle_pct) begin
            start   <= 1'b1;
            i_order <= pending_orders[0];
            pending_orders.delete(0);
        end
    end

    // Monitor: compare every strobed record with the oldest expectation.
    always @(posedge i_clk) begin
        lom_pkg::t_record e;
        cycles++;
        if (i_rst_n && o_strobe) begin
            n_records++;
            if (expected_records.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected record %h", $time, o_record);
            end else begin
                e = expected_records[0];
                expected_records.delete(0);
                if (o_record !== e) begin
                    n_errors++;
                    $display("%0t: record mismatch expected %h actual %h", $time, e, o_record);
                    if (o_record.record_kind !== e.record_kind)
                        $display("  record_kind expected %0d actual %0d", e.record_kind,
                                 o_record.record_kind);
                    if (o_record.trade_id !== e.trade_id)
                        $display("  trade_id expected %0d actual %0d", e.trade_id,
                                 o_record.trade_id);
                    if (o_record.fill_quantity !== e.fill_quantity)
                        $display("  fill_quantity expected %0d actual %0d", e.fill_quantity,
                                 o_record.fill_quantity);
                    if (o_record.outcome !== e.outcome)
                        $display("  outcome expected %0d actual %0d", e.outcome,
                                 o_record.outcome);
                end
            end
        end
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Wait until the queue of pending transactions has been taken.
    task automatic wait_taken();
        while (pending_orders.size() > 0 || start) @(posedge i_clk);
    endtask

    // Build one random order; mostly limits near a narrow band so books cross.
    function automatic lom_pkg::t_order random_order();
        int px;
        int qty;
        int pick;
        pick = $urandom_range(99);
        px   = (pick < 85) ? 120 + $urandom_range(15) : $urandom_range(255);
        pick = $urandom_range(99);
        if (pick < 3) qty = 0;
        else if (pick < 8) qty = $urandom_range(65535);
        else qty = $urandom_range(1, 60);
        return make_order($urandom_range(1), $urandom_range(99) < 15, px, qty);
    endfunction

    initial begin
        lom_pkg::t_order o;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, both sides and kinds, zero quantity, a deep sweep.
        queue_order(make_order(1'b0, 1'b1, 0, 5));      // market into empty book
        queue_order(make_order(1'b0, 1'b0, 0, 0));      // zero quantity
        queue_order(make_order(1'b1, 1'b0, 255, 65535));
        queue_order(make_order(1'b1, 1'b0, 0, 1));
        queue_order(make_order(1'b0, 1'b0, 255, 10));   // crosses both asks
        queue_order(make_order(1'b0, 1'b0, 0, 7));
        queue_order(make_order(1'b0, 1'b0, 0, 3));      // same level, FIFO
        queue_order(make_order(1'b1, 1'b1, 200, 8));    // market sell sweeps bids
        for (int k = 0; k < 34; k++)                     // fill bid side to overflow
            queue_order(make_order(1'b0, 1'b0, k % 4, 1));
        o = make_order(1'b1, 1'b1, 255, 65535);          // sweep many resting bids
        o.order_id  = 32'hFFFF_FFFF;
        o.timestamp = 48'hFFFF_FFFF_FFFF;
        queue_order(o);
        wait_taken();

        // Pause until the book is settled before the random phases.
        drain_hold = 1'b1;
        while (expected_records.size() > 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        drain_hold = 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 3) ? 21 : 53;
            for (int k = 0; k < N_RANDOM / 4; k++) queue_order(random_order());
            wait_taken();
        end
        stim_done = 1'b1;

        while (expected_records.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("Ran %0d orders, %0d trades, %0d records checked.", n_orders, n_trades,
                 n_records);
        $display("Outcomes: filled %0d, rested %0d, dropped %0d, rejected %0d.",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
        if (n_errors == 0 && expected_records.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== limit_order_matching_engine_top.f =====
+incdir+hdl
hdl/lom_pkg.sv
hdl/lom_cell.sv
hdl/lom_chain.sv
hdl/limit_order_matching_engine_top.sv
hdl/lom_checker.sv
sim/tb_limit_order_matching_engine_top.sv
